[rtl/btpc_pkg.sv]
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types, constants and helpers for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int NUM_STAGES = 15;

  typedef enum logic [1:0] {
    REG_TEMP_COEFFS = 2'd0,
    REG_PRESS_A     = 2'd1,
    REG_PRESS_B     = 2'd2,
    REG_PRESS_C     = 2'd3
  } reg_idx_t;

  // Signed divide by 2^k, truncating toward zero.
  function automatic logic signed [63:0] sdiv2(input logic signed [63:0] v, input int k);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

endpackage

[rtl/baro_temp_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation with 64-bit wrapping math.
// ----------------------------------------------------------------------------
// Takes one raw temperature/pressure pair per cycle while the output keeps up
// and returns the temperature in 0.01 degC and the pressure in 0.01 Pa. The
// datapath is a 15-stage pipeline, and a new request can be accepted every
// cycle while the output keeps up. Wide
// 64-bit products are formed from 32-bit partial products in one stage and
// summed in the next, which sets the stage count. Coefficients are written over
// the APB port at byte addresses 0, 8, 16 and 24 and must stay fixed while
// requests are in flight.
module baro_temp_pressure_compensation (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [23:0]         raw_temp,
  input  logic [23:0]         raw_press,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  temp_centi_c,
  output logic [31:0]         press_centi_pa
);
  import btpc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  logic [39:0] temp_coeffs;
  logic [47:0] press_coeffs_a;
  logic [47:0] press_coeffs_b;
  logic [31:0] press_coeffs_c;
  reg_idx_t    reg_idx;
  logic        reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:3]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs    <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
      press_coeffs_c <= '0;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_TEMP_COEFFS: temp_coeffs    <= pwdata[39:0];
        REG_PRESS_A:     press_coeffs_a <= pwdata[47:0];
        REG_PRESS_B:     press_coeffs_b <= pwdata[47:0];
        REG_PRESS_C:     press_coeffs_c <= pwdata[31:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TEMP_COEFFS: prdata = {24'h0, temp_coeffs};
      REG_PRESS_A:     prdata = {16'h0, press_coeffs_a};
      REG_PRESS_B:     prdata = {16'h0, press_coeffs_b};
      REG_PRESS_C:     prdata = {32'h0, press_coeffs_c};
    endcase
  end

  // Coefficient fields
  logic [15:0]        t1;
  logic signed [16:0] t2s;
  logic signed [7:0]  t3;
  logic signed [15:0] p1, p2, p9;
  logic signed [7:0]  p3, p4, p7, p8, p10, p11;
  logic [15:0]        p5;
  logic signed [16:0] p6s;
  logic signed [17:0] p1m, p2m;

  assign t1  = temp_coeffs[15:0];
  assign t2s = $signed({1'b0, temp_coeffs[31:16]});
  assign t3  = $signed(temp_coeffs[39:32]);
  assign p1  = $signed(press_coeffs_a[15:0]);
  assign p2  = $signed(press_coeffs_a[31:16]);
  assign p3  = $signed(press_coeffs_a[39:32]);
  assign p4  = $signed(press_coeffs_a[47:40]);
  assign p5  = press_coeffs_b[15:0];
  assign p6s = $signed({1'b0, press_coeffs_b[31:16]});
  assign p7  = $signed(press_coeffs_b[39:32]);
  assign p8  = $signed(press_coeffs_b[47:40]);
  assign p9  = $signed(press_coeffs_c[15:0]);
  assign p10 = $signed(press_coeffs_c[23:16]);
  assign p11 = $signed(press_coeffs_c[31:24]);
  assign p1m = 18'(p1) - 18'sd16384;
  assign p2m = 18'(p2) - 18'sd16384;

  // --------------------------------------------------------------------------
  // Pipeline control
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage registers
  logic signed [24:0] s1_d;
  logic [23:0]        s1_rp;
  logic signed [41:0] s2_a;
  logic signed [49:0] s2_dd;
  logic [23:0]        s2_rp;
  logic signed [59:0] s3_ts;
  logic [23:0]        s3_rp;
  logic signed [27:0] s4_tlin;
  logic [23:0]        s4_rp;
  logic signed [55:0] s5_sq;
  logic signed [32:0] s5_t25;
  logic signed [44:0] s5_q6;
  logic signed [45:0] s5_q2;
  logic signed [36:0] s5_y0;
  logic [47:0]        s5_rr;
  logic signed [27:0] s5_tlin;
  logic [23:0]        s5_rp;
  logic [31:0]        s6_temp;
  logic signed [60:0] s6_cl;
  logic signed [44:0] s6_ch;
  logic signed [63:0] s6_o7, s6_s3;
  logic signed [61:0] s6_y1;
  logic signed [56:0] s6_z1;
  logic signed [44:0] s6_q6;
  logic signed [45:0] s6_q2;
  logic [23:0]        s6_rp;
  logic [31:0]        s7_temp;
  logic [63:0]        s7_cw;
  logic signed [47:0] s7_y2;
  logic signed [40:0] s7_z2;
  logic signed [63:0] s7_o7, s7_s3;
  logic signed [44:0] s7_q6;
  logic signed [45:0] s7_q2;
  logic [23:0]        s7_rp;
  logic [31:0]        s8_temp;
  logic signed [56:0] s8_cube;
  logic signed [57:0] s8_yl, s8_zl;
  logic [31:0]        s8_yh, s8_zh;
  logic [63:0]        s8_offp, s8_sensp;
  logic [23:0]        s8_rp;
  logic [31:0]        s9_temp;
  logic signed [63:0] s9_m8, s9_m4, s9_y3, s9_z3;
  logic [63:0]        s9_offp, s9_sensp;
  logic [23:0]        s9_rp;
  logic [31:0]        s10_temp;
  logic signed [63:0] s10_m8d, s10_m4d, s10_y4, s10_z4;
  logic [63:0]        s10_offp, s10_sensp;
  logic [23:0]        s10_rp;
  logic [31:0]        s11_temp;
  logic [63:0]        s11_off, s11_sens, s11_yz;
  logic [23:0]        s11_rp;
  logic [31:0]        s12_temp;
  logic signed [63:0] s12_w;
  logic signed [39:0] s12_sd;
  logic [63:0]        s12_yz;
  logic [23:0]        s12_rp;
  logic [31:0]        s13_temp;
  logic signed [57:0] s13_xl;
  logic [31:0]        s13_xh;
  logic [63:0]        s13_wyz;
  logic [31:0]        s14_temp;
  logic [63:0]        s14_sum;
  logic [31:0]        s15_temp;
  logic [31:0]        s15_press;

  // --------------------------------------------------------------------------
  // Stage logic
  logic signed [25:0] d_full;
  logic signed [41:0] a_prod;
  logic signed [49:0] dd_prod;
  logic signed [57:0] b_prod;
  logic signed [59:0] ts_sum;
  logic signed [63:0] tlin_full;
  logic signed [55:0] sq_prod;
  logic signed [32:0] t25_prod;
  logic signed [44:0] q6_prod;
  logic signed [45:0] q2_prod;
  logic signed [35:0] y0a_prod;
  logic signed [36:0] y0_sum;
  logic [47:0]        rr_prod;
  logic signed [63:0] temp_full;
  logic [47:0]        sqd;
  logic signed [60:0] cl_prod;
  logic signed [44:0] ch_prod;
  logic signed [63:0] o7_prod, s3_prod;
  logic signed [61:0] y1_prod;
  logic signed [56:0] z1_prod;
  logic signed [24:0] rp5_s, rp6_s, rp7_s, rp12_s;
  logic [63:0]        cw_sum;
  logic signed [63:0] y2_full, z2_full, cube_full;
  logic signed [57:0] yl_prod, zl_prod, xl_prod;
  logic signed [40:0] yh_prod;
  logic signed [33:0] zh_prod;
  logic signed [32:0] xh_prod;
  logic [63:0]        offp_sum, sensp_sum;
  logic signed [63:0] m8_prod, m4_prod;
  logic signed [63:0] sd_full;
  logic [63:0]        p25_prod;

  assign rp5_s  = $signed({1'b0, s5_rp});
  assign rp6_s  = $signed({1'b0, s6_rp});
  assign rp7_s  = $signed({1'b0, s7_rp});
  assign rp12_s = $signed({1'b0, s12_rp});

  always_comb begin
    d_full    = $signed({2'b00, raw_temp}) - $signed({2'b00, t1, 8'h00});
    a_prod    = s1_d * t2s;
    dd_prod   = s1_d * s1_d;
    b_prod    = s2_dd * t3;
    ts_sum    = (60'(s2_a) <<< 18) + 60'(b_prod);
    tlin_full = sdiv2(64'(s3_ts), 32);
    sq_prod   = s4_tlin * s4_tlin;
    t25_prod  = 33'(s4_tlin) * 33'sd25;
    q6_prod   = s4_tlin * p6s;
    q2_prod   = s4_tlin * p2m;
    y0a_prod  = s4_tlin * p10;
    y0_sum    = 37'(y0a_prod) + 37'($signed({p9, 16'h0000}));
    rr_prod   = s4_rp * s4_rp;
    temp_full = sdiv2(64'(s5_t25), 14);
    // square is never negative, so the divide by 64 is a plain shift
    sqd       = s5_sq[53:6];
    cl_prod   = $signed({1'b0, sqd[31:0]}) * s5_tlin;
    ch_prod   = $signed({1'b0, sqd[47:32]}) * s5_tlin;
    o7_prod   = p7 * s5_sq;
    s3_prod   = p3 * s5_sq;
    y1_prod   = s5_y0 * rp5_s;
    z1_prod   = p11 * $signed({1'b0, s5_rr});
    cw_sum    = 64'(s6_cl) + {s6_ch[31:0], 32'h0};
    y2_full   = sdiv2(64'(s6_y1), 13);
    z2_full   = sdiv2(64'(s6_z1), 16);
    cube_full = sdiv2($signed(s7_cw), 8);
    yl_prod   = $signed({1'b0, s7_y2[31:0]}) * rp7_s;
    yh_prod   = $signed(s7_y2[47:32]) * rp7_s;
    zl_prod   = $signed({1'b0, s7_z2[31:0]}) * rp7_s;
    zh_prod   = $signed(s7_z2[40:32]) * rp7_s;
    offp_sum  = {1'b0, p5, 47'h0} + 64'(s7_o7 <<< 4) + (64'(s7_q6) <<< 22);
    sensp_sum = {p1m, 46'h0} + 64'(s7_s3 <<< 2) + (64'(s7_q2) <<< 21);
    m8_prod   = s8_cube * p8;
    m4_prod   = s8_cube * p4;
    sd_full   = sdiv2($signed(s11_sens), 24);
    xl_prod   = $signed({1'b0, s12_sd[31:0]}) * rp12_s;
    xh_prod   = $signed(s12_sd[39:32]) * rp12_s;
    p25_prod  = s14_sum * 64'd25;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_d  <= d_full[24:0];
      s1_rp <= raw_press;
    end
    if (adv[1]) begin
      s2_a  <= a_prod;
      s2_dd <= dd_prod;
      s2_rp <= s1_rp;
    end
    if (adv[2]) begin
      s3_ts <= ts_sum;
      s3_rp <= s2_rp;
    end
    if (adv[3]) begin
      s4_tlin <= tlin_full[27:0];
      s4_rp   <= s3_rp;
    end
    if (adv[4]) begin
      s5_sq   <= sq_prod;
      s5_t25  <= t25_prod;
      s5_q6   <= q6_prod;
      s5_q2   <= q2_prod;
      s5_y0   <= y0_sum;
      s5_rr   <= rr_prod;
      s5_tlin <= s4_tlin;
      s5_rp   <= s4_rp;
    end
    if (adv[5]) begin
      s6_temp <= temp_full[31:0];
      s6_cl   <= cl_prod;
      s6_ch   <= ch_prod;
      s6_o7   <= o7_prod;
      s6_s3   <= s3_prod;
      s6_y1   <= y1_prod;
      s6_z1   <= z1_prod;
      s6_q6   <= s5_q6;
      s6_q2   <= s5_q2;
      s6_rp   <= s5_rp;
    end
    if (adv[6]) begin
      s7_temp <= s6_temp;
      s7_cw   <= cw_sum;
      s7_y2   <= y2_full[47:0];
      s7_z2   <= z2_full[40:0];
      s7_o7   <= s6_o7;
      s7_s3   <= s6_s3;
      s7_q6   <= s6_q6;
      s7_q2   <= s6_q2;
      s7_rp   <= s6_rp;
    end
    if (adv[7]) begin
      s8_temp  <= s7_temp;
      s8_cube  <= cube_full[56:0];
      s8_yl    <= yl_prod;
      s8_yh    <= yh_prod[31:0];
      s8_zl    <= zl_prod;
      s8_zh    <= zh_prod[31:0];
      s8_offp  <= offp_sum;
      s8_sensp <= sensp_sum;
      s8_rp    <= s7_rp;
    end
    if (adv[8]) begin
      s9_temp  <= s8_temp;
      s9_m8    <= m8_prod;
      s9_m4    <= m4_prod;
      s9_y3    <= $signed(64'(s8_yl) + {s8_yh, 32'h0});
      s9_z3    <= $signed(64'(s8_zl) + {s8_zh, 32'h0});
      s9_offp  <= s8_offp;
      s9_sensp <= s8_sensp;
      s9_rp    <= s8_rp;
    end
    if (adv[9]) begin
      s10_temp  <= s9_temp;
      s10_m8d   <= sdiv2(s9_m8, 5);
      s10_m4d   <= sdiv2(s9_m4, 5);
      s10_y4    <= sdiv2(s9_y3, 9);
      s10_z4    <= sdiv2(s9_z3, 7);
      s10_offp  <= s9_offp;
      s10_sensp <= s9_sensp;
      s10_rp    <= s9_rp;
    end
    if (adv[10]) begin
      s11_temp <= s10_temp;
      s11_off  <= s10_offp + s10_m8d;
      s11_sens <= s10_sensp + s10_m4d;
      s11_yz   <= s10_y4 + s10_z4;
      s11_rp   <= s10_rp;
    end
    if (adv[11]) begin
      s12_temp <= s11_temp;
      s12_w    <= sdiv2($signed(s11_off), 2);
      s12_sd   <= sd_full[39:0];
      s12_yz   <= s11_yz;
      s12_rp   <= s11_rp;
    end
    if (adv[12]) begin
      s13_temp <= s12_temp;
      s13_xl   <= xl_prod;
      s13_xh   <= xh_prod[31:0];
      s13_wyz  <= s12_w + s12_yz;
    end
    if (adv[13]) begin
      s14_temp <= s13_temp;
      s14_sum  <= s13_wyz + 64'(s13_xl) + {s13_xh, 32'h0};
    end
    if (adv[14]) begin
      s15_temp  <= s14_temp;
      // top 24 bits of a 64-bit word: never reaches the 32-bit clamp
      s15_press <= {8'h00, p25_prod[63:40]};
    end
  end

  assign temp_centi_c   = $signed(s15_temp);
  assign press_centi_pa = s15_press;

  // --------------------------------------------------------------------------
  // Assertions
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld && !out_ready) |-> !in_ready)
    else $error("request accepted while pipeline full and stalled");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted request missing from first stage");

  a_press_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (press_centi_pa[31:24] == 8'h00))
    else $error("pressure result beyond 24 bits");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the barometric temperature/pressure compensation pipeline.
// ----------------------------------------------------------------------------
// Computes the expected temperature and pressure for every accepted request
// with 64-bit wrapping integer math and checks each result in order. Runs
// directed corner requests, then random requests under several coefficient
// sets, with random idling on both channels and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic signed [31:0] temp;
    logic [31:0]        press;
  } comp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] raw_temp = '0, raw_press = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] temp_centi_c;
  logic [31:0] press_centi_pa;

  // coefficient copies for the predictor
  logic [63:0] temp_coeffs, press_a, press_b, press_c;

  comp_result_t expected_q[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  busy_idle = 1'b1;   // random idling on both channels
  bit  hold_output = 1'b0;

  baro_temp_pressure_compensation dut (.*);

  always #4 clk = ~clk;

  function automatic logic [63:0] trunc_shift(logic [63:0] v, int k);
    logic [63:0] mag;
    if (v[63]) begin
      mag = (64'd0 - v) >> k;
      return 64'd0 - mag;
    end
    return v >> k;
  endfunction

  function automatic logic [63:0] sx(logic [63:0] r, int pos, int bits);
    logic [63:0] m, v, s;
    m = (64'd1 << bits) - 64'd1;
    v = (r >> pos) & m;
    s = 64'd1 << (bits - 1);
    return (v ^ s) - s;
  endfunction

  function automatic comp_result_t compensate(logic [23:0] rt_in, logic [23:0] rp_in);
    logic [63:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic [63:0] d, tlin, tc, sq, cube, offset, sens, x, y, z, w, sum, pr;
    comp_result_t res;
    rt = {40'd0, rt_in};
    rp = {40'd0, rp_in};
    t1 = {48'd0, temp_coeffs[15:0]};
    t2 = {48'd0, temp_coeffs[31:16]};
    t3 = sx(temp_coeffs, 32, 8);
    p1 = sx(press_a, 0, 16);
    p2 = sx(press_a, 16, 16);
    p3 = sx(press_a, 32, 8);
    p4 = sx(press_a, 40, 8);
    p5 = {48'd0, press_b[15:0]};
    p6 = {48'd0, press_b[31:16]};
    p7 = sx(press_b, 32, 8);
    p8 = sx(press_b, 40, 8);
    p9 = sx(press_c, 0, 16);
    p10 = sx(press_c, 16, 8);
    p11 = sx(press_c, 24, 8);
    d = rt - t1 * 64'd256;
    tlin = trunc_shift((t2 * d) * 64'd262144 + d * d * t3, 32);
    tc = trunc_shift(tlin * 64'd25, 14);
    sq = tlin * tlin;
    cube = trunc_shift(trunc_shift(sq, 6) * tlin, 8);
    offset = p5 * 64'd140737488355328 + trunc_shift(p8 * cube, 5)
           + p7 * sq * 64'd16 + p6 * tlin * 64'd4194304;
    sens = (p1 - 64'd16384) * 64'd70368744177664 + trunc_shift(p4 * cube, 5)
         + p3 * sq * 64'd4 + (p2 - 64'd16384) * tlin * 64'd2097152;
    x = trunc_shift(sens, 24) * rp;
    y = p10 * tlin + p9 * 64'd65536;
    y = trunc_shift(y * rp, 13);
    y = trunc_shift(y * rp, 9);
    z = trunc_shift(p11 * (rp * rp), 16);
    z = trunc_shift(z * rp, 7);
    w = trunc_shift(offset, 2);
    sum = w + x + y + z;
    pr = (sum * 64'd25) >> 40;
    if (pr > 64'hFFFF_FFFF) pr = 64'hFFFF_FFFF;
    res.temp = tc[31:0];
    res.press = pr[31:0];
    return res;
  endfunction

  // output side: random stall, long hold when requested
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_output) out_ready <= 1'b0;
    else if (busy_idle) out_ready <= ($urandom_range(99) >= 28);
    else out_ready <= 1'b1;
  end

  // result checker
  always @(posedge clk) begin
    comp_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result temp=%0d press=%0d", temp_centi_c, press_centi_pa);
      end else begin
        exp_r = expected_q.pop_front();
        if (temp_centi_c !== exp_r.temp || press_centi_pa !== exp_r.press) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: temp exp %0d got %0d, press exp %0d got %0d",
                     exp_r.temp, temp_centi_c, exp_r.press, press_centi_pa);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || hold_output)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx) << 3; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TEMP_COEFFS: temp_coeffs = value & 64'hFF_FFFF_FFFF;
      REG_PRESS_A:     press_a = value & 64'hFFFF_FFFF_FFFF;
      REG_PRESS_B:     press_b = value & 64'hFFFF_FFFF_FFFF;
      default:         press_c = value & 64'hFFFF_FFFF;
    endcase
  endtask

  // send one request; called just after a falling edge. Valid stays high
  // after acceptance so a following request can go out back to back; an idle
  // cycle or wait_drained drops it.
  task automatic send_request(logic [23:0] rt, logic [23:0] rp);
    if (busy_idle)
      while ($urandom_range(99) < 28) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1; raw_temp <= rt; raw_press <= rp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(compensate(rt, rp));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_coeffs(logic [63:0] tc, logic [63:0] pa, logic [63:0] pb,
                             logic [63:0] pc);
    wait_drained();
    write_reg(REG_TEMP_COEFFS, tc);
    write_reg(REG_PRESS_A, pa);
    write_reg(REG_PRESS_B, pb);
    write_reg(REG_PRESS_C, pc);
  endtask

  // typical calibration-like values
  task automatic load_typical();
    load_coeffs({8'hF9, 16'd19000, 16'd27500},
                {8'd6, 8'hFA, 16'hFF80, 16'hFFF0},
                {8'hFC, 8'd15, 16'd32000, 16'd25000},
                {8'hF0, 8'd12, 16'd5000});
  endtask

  task automatic test_directed();
    load_typical();
    send_request(24'h000000, 24'h000000);
    send_request(24'hFFFFFF, 24'hFFFFFF);
    send_request(24'h6B0000, 24'h600000);
    send_request(24'h000000, 24'hFFFFFF);
    send_request(24'hFFFFFF, 24'h000000);
    send_request(24'hAAAAAA, 24'h555555);
    send_request(24'h555555, 24'hAAAAAA);
    // extreme coefficients: wrapping overflow and negative polynomials
    load_coeffs(64'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF,
                64'hFFFF_FFFF);
    send_request(24'h000000, 24'hFFFFFF);
    send_request(24'hFFFFFF, 24'hFFFFFF);
    send_request(24'h123456, 24'h800000);
    load_coeffs(64'h80_0000_FFFF, 64'h8080_8000_8000, 64'h8080_FFFF_0000,
                64'h8080_8000);
    send_request(24'h000000, 24'hFFFFFF);
    send_request(24'hFFFFFF, 24'h7FFFFF);
    send_request(24'h800000, 24'h000001);
    load_coeffs(64'h7F_FFFF_0000, 64'h7F7F_7FFF_7FFF, 64'h7F7F_0000_FFFF,
                64'h7F7F_7FFF);
    send_request(24'hFFFFFF, 24'hFFFFFF);
    send_request(24'h000000, 24'h000000);
    send_request(24'h000001, 24'hFFFFFE);
    // all-zero coefficients
    load_coeffs('0, '0, '0, '0);
    send_request(24'hFFFFFF, 24'hFFFFFF);
    send_request(24'h400000, 24'h400000);
  endtask

  task automatic random_burst(int count);
    repeat (count) begin
      if ($urandom_range(3) == 0)
        send_request(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)));
      else
        send_request(24'(24'h600000 + $urandom_range(24'h1FFFFF)),
                     24'(24'h400000 + $urandom_range(24'h3FFFFF)));
    end
  endtask

  task automatic test_random();
    load_typical();
    random_burst(200);
    load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {32'd0, $urandom});
    random_burst(150);
    // no idling at all for a stretch
    busy_idle = 1'b0;
    load_typical();
    random_burst(120);
    busy_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_output = 1'b1;
        repeat (300) @(negedge clk);
        hold_output = 1'b0;
      end
      random_burst(60);
    join
    // sender pauses until everything has drained
    wait_drained();
    random_burst(70);
  endtask

  initial begin
    temp_coeffs = '0; press_a = '0; press_b = '0; press_c = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && expected_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
